/* rtl/core/dwc_pkg.sv */
package dwc_pkg;

    localparam int unsigned DECIMATION_DEFAULT = 8;
    localparam int unsigned MAX_WINDOW_DEFAULT = 44096;
    localparam int unsigned AUDIO_RATE_HZ      = 44100;
    localparam int unsigned WINDOW_RESET       = 11024;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned MIX_W    = 17;
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned OUT_W    = 56;

    typedef enum logic {
        FUNC_FRAME   = 1'b0,
        FUNC_RELEASE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OPEN      = 2'd0,
        STATUS_HANDOFF   = 2'd1,
        STATUS_COOLDOWN  = 2'd2,
        STATUS_DISCARDED = 2'd3
    } status_t;

    typedef struct packed {
        func_t                func;
        logic [SAMPLE_W-1:0]  left_sample;
        logic [SAMPLE_W-1:0]  right_sample;
    } item_t;

endpackage

/* rtl/core/dwc_in_reg.sv */
module dwc_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  dwc_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output dwc_pkg::item_t out_item
);

    logic           valid_reg;
    dwc_pkg::item_t item_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

/* rtl/core/dwc_capture.sv */
module dwc_capture #(
    parameter int unsigned DECIMATION = dwc_pkg::DECIMATION_DEFAULT,
    parameter int unsigned MAX_WINDOW = dwc_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [15:0]                cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  dwc_pkg::item_t             in_item,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [dwc_pkg::OUT_W-1:0]  m_tdata
);

    localparam int unsigned PHASE_W    = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam int unsigned MIN_WINDOW = dwc_pkg::AUDIO_RATE_HZ / DECIMATION;
    localparam int unsigned RST_LO     = (dwc_pkg::WINDOW_RESET < MIN_WINDOW) ?
                                         MIN_WINDOW : dwc_pkg::WINDOW_RESET;
    localparam int unsigned RST_WINDOW = (RST_LO > MAX_WINDOW) ? MAX_WINDOW : RST_LO;
    localparam int unsigned AW         = dwc_pkg::ADDR_W;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [AW-1:0]      fill_reg, fill_next;
    logic               active_reg, active_next;
    logic               cooldown_reg, cooldown_next;
    logic               pending_reg, pending_next;
    logic               pending_buf_reg, pending_buf_next;
    logic [AW-1:0]      window_reg;
    logic [AW-1:0]      cfg_lo, cfg_clamped;

    logic                          valid_reg;
    logic [dwc_pkg::OUT_W-1:0]     data_reg, data_next;
    logic                          emit;
    logic                          kept;
    logic [AW-1:0]                 fill_inc;
    logic [dwc_pkg::MIX_W-1:0]     mix;
    dwc_pkg::status_t              status;
    logic                          hbuf;
    logic [AW-1:0]                 hlen;

    assign in_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    assign cfg_lo      = (cfg_wr_data < AW'(MIN_WINDOW)) ? AW'(MIN_WINDOW) : cfg_wr_data;
    assign cfg_clamped = (cfg_lo > AW'(MAX_WINDOW)) ? AW'(MAX_WINDOW) : cfg_lo;

    always_comb begin
        phase_next       = phase_reg;
        fill_next        = fill_reg;
        active_next      = active_reg;
        cooldown_next    = cooldown_reg;
        pending_next     = pending_reg;
        pending_buf_next = pending_buf_reg;
        emit             = 1'b0;
        status           = dwc_pkg::STATUS_OPEN;
        hbuf             = 1'b0;
        hlen             = '0;
        kept             = (phase_reg == '0);
        fill_inc         = fill_reg + AW'(1);
        mix = {in_item.left_sample[15], in_item.left_sample}
            + {in_item.right_sample[15], in_item.right_sample};

        if (in_valid && in_ready) begin
            case (in_item.func)
                dwc_pkg::FUNC_RELEASE: begin
                    pending_next = 1'b0;
                end
                dwc_pkg::FUNC_FRAME: begin
                    phase_next = (phase_reg == PHASE_W'(DECIMATION - 1)) ?
                                 '0 : phase_reg + PHASE_W'(1);
                    if (kept) begin
                        emit      = 1'b1;
                        fill_next = fill_inc;
                        if (fill_inc >= window_reg) begin
                            fill_next = '0;
                            if (cooldown_reg) begin
                                cooldown_next = 1'b0;
                                status        = dwc_pkg::STATUS_COOLDOWN;
                            end else if (!pending_reg) begin
                                pending_next     = 1'b1;
                                pending_buf_next = active_reg;
                                hbuf             = active_reg;
                                hlen             = fill_inc;
                                active_next      = !active_reg;
                                cooldown_next    = 1'b1;
                                status           = dwc_pkg::STATUS_HANDOFF;
                            end else begin
                                status = dwc_pkg::STATUS_DISCARDED;
                            end
                        end
                    end
                end
                default: begin
                    pending_next = pending_reg;
                end
            endcase
        end

        // {pad, handoff_length, handoff_buffer, window_status, write_address,
        //  buffer_select, mixed_sample}
        data_next = {3'b000, hlen, hbuf, status, fill_reg, active_reg, mix};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= '0;
            fill_reg        <= '0;
            active_reg      <= 1'b0;
            cooldown_reg    <= 1'b0;
            pending_reg     <= 1'b0;
            pending_buf_reg <= 1'b0;
            window_reg      <= AW'(RST_WINDOW);
            valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                window_reg   <= cfg_clamped;
                phase_reg    <= '0;
                fill_reg     <= '0;
                cooldown_reg <= 1'b0;
                pending_reg  <= 1'b0;
            end else begin
                phase_reg    <= phase_next;
                fill_reg     <= fill_next;
                cooldown_reg <= cooldown_next;
                pending_reg  <= pending_next;
            end
            active_reg      <= active_next;
            pending_buf_reg <= pending_buf_next;
            if (in_ready) begin
                valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/core/decimating_window_capture.sv */
// Decimating window capture. Stereo frames arrive on the s_ stream (s_tuser low);
// one frame in DECIMATION is kept, mixed to a 17-bit left+right sum and sent on the
// m_ stream with its ping-pong buffer and write address for an external buffer
// memory. The result of the last sample of a window carries the window status and,
// on a handoff, the handed-off buffer and its length. A request with s_tuser high
// releases the handed-off buffer and gives no result. Writing window_length
// (clamped to 44100/DECIMATION..MAX_WINDOW) restarts capture; write only while idle.
// Rate: one request per cycle while m_tready keeps up; each accepted request passes
// the input register, then the state update and the result register.
module decimating_window_capture #(
    parameter int unsigned DECIMATION = dwc_pkg::DECIMATION_DEFAULT,
    parameter int unsigned MAX_WINDOW = dwc_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // window_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // left_sample, right_sample
    input  logic [0:0]  s_tuser,       // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata        // mixed_sample, buffer_select, write_address,
                                       // window_status, handoff_buffer,
                                       // handoff_length, zero pad
);

    dwc_pkg::item_t s_item;
    dwc_pkg::item_t q_item;
    logic           q_valid;
    logic           q_ready;

    assign s_item.func         = dwc_pkg::func_t'(s_tuser[0]);
    assign s_item.left_sample  = s_tdata[15:0];
    assign s_item.right_sample = s_tdata[31:16];

    dwc_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    dwc_capture #(
        .DECIMATION (DECIMATION),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_capture (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_item     (q_item),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam logic [15:0] MIN_WINDOW_LEN =
        16'(dwc_pkg::AUDIO_RATE_HZ / dwc_pkg::DECIMATION_DEFAULT);
    localparam logic [15:0] MAX_WINDOW_LEN = 16'(dwc_pkg::MAX_WINDOW_DEFAULT);
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [15:0]       handoff_length;
        logic              handoff_buffer;
        dwc_pkg::status_t  window_status;
        logic [15:0]       write_address;
        logic              buffer_select;
        logic [16:0]       mixed_sample;
    } capture_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;       // left_sample, right_sample
    logic [0:0]  s_tuser;       // func
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;       // mixed_sample, buffer_select, write_address,
                                // window_status, handoff_buffer, handoff_length, pad

    capture_result_t expected_samples[$];
    int unsigned     mismatch_count;
    bit              idle_on;
    bit              sparse_idle;
    bit              hold_request;

    // predicted block state
    logic [2:0]  pred_phase;
    logic [15:0] pred_fill;
    logic        pred_buffer;
    logic        pred_cooldown;
    logic        pred_pending;
    logic [15:0] pred_window;

    decimating_window_capture i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #100_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (sparse_idle) begin
            return (r < 97) ? 0 : $urandom_range(1, 3);
        end
        if (r < 70) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] clamp_window_length(input logic [15:0] v);
        logic [15:0] w;
        w = v;
        if (w < MIN_WINDOW_LEN) begin
            w = MIN_WINDOW_LEN;
        end
        if (w > MAX_WINDOW_LEN) begin
            w = MAX_WINDOW_LEN;
        end
        return w;
    endfunction

    task automatic restart_prediction();
        pred_phase    = '0;
        pred_fill     = '0;
        pred_cooldown = 1'b0;
        pred_pending  = 1'b0;
    endtask

    task automatic predict_capture(input dwc_pkg::func_t f, input logic [15:0] l,
                                   input logic [15:0] r);
        capture_result_t e;
        logic            kept;
        if (f == dwc_pkg::FUNC_RELEASE) begin
            pred_pending = 1'b0;
            return;
        end
        kept       = (pred_phase == 0);
        pred_phase = 3'((pred_phase + 1) % dwc_pkg::DECIMATION_DEFAULT);
        if (!kept) begin
            return;
        end
        e.mixed_sample   = {l[15], l} + {r[15], r};
        e.buffer_select  = pred_buffer;
        e.write_address  = pred_fill;
        e.window_status  = dwc_pkg::STATUS_OPEN;
        e.handoff_buffer = 1'b0;
        e.handoff_length = '0;
        pred_fill        = pred_fill + 16'd1;
        if (pred_fill >= pred_window) begin
            if (pred_cooldown) begin
                pred_cooldown   = 1'b0;
                e.window_status = dwc_pkg::STATUS_COOLDOWN;
            end else if (!pred_pending) begin
                pred_pending     = 1'b1;
                e.handoff_buffer = pred_buffer;
                e.handoff_length = pred_fill;
                pred_buffer      = ~pred_buffer;
                pred_cooldown    = 1'b1;
                e.window_status  = dwc_pkg::STATUS_HANDOFF;
            end else begin
                e.window_status = dwc_pkg::STATUS_DISCARDED;
            end
            pred_fill = '0;
        end
        expected_samples.push_back(e);
    endtask

    // caller stands at a rising edge
    task automatic send_request(input dwc_pkg::func_t f, input logic [15:0] l,
                                input logic [15:0] r);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {r, l};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        predict_capture(f, l, r);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window_length(input logic [15:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        pred_window = clamp_window_length(v);
        restart_prediction();
    endtask

    task automatic check_field(input string name, input logic [16:0] exp_v,
                               input logic [16:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input logic [55:0] d);
        capture_result_t got;
        capture_result_t e;
        got = d[52:0];
        if (expected_samples.size() == 0) begin
            $display("%0t: result with nothing expected, got %h", $time, d);
            mismatch_count++;
            return;
        end
        e = expected_samples.pop_front();
        check_field("mixed_sample", e.mixed_sample, got.mixed_sample);
        check_field("buffer_select", 17'(e.buffer_select), 17'(got.buffer_select));
        check_field("write_address", 17'(e.write_address), 17'(got.write_address));
        check_field("window_status", 17'(e.window_status), 17'(got.window_status));
        check_field("handoff_buffer", 17'(e.handoff_buffer), 17'(got.handoff_buffer));
        check_field("handoff_length", 17'(e.handoff_length), 17'(got.handoff_length));
    endtask

    initial begin : result_monitor
        int unsigned stall;
        int unsigned hold;
        stall = 0;
        hold  = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                check_result(m_tdata);
            end
            if (hold_request) begin
                hold         = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic test_directed_frames();
        logic [15:0] left_vals[3]  = '{16'h8000, 16'h7FFF, 16'h8000};
        logic [15:0] right_vals[3] = '{16'h8000, 16'h7FFF, 16'h7FFF};
        for (int k = 0; k < 3; k++) begin
            send_request(dwc_pkg::FUNC_FRAME, left_vals[k], right_vals[k]);
            for (int d = 1; d < 8; d++) begin
                // release with nothing pending, mid decimation
                if (k == 1 && d == 3) begin
                    send_request(dwc_pkg::FUNC_RELEASE, 16'hFFFF, 16'hFFFF);
                end
                send_request(dwc_pkg::FUNC_FRAME, 16'($urandom()), 16'($urandom()));
            end
        end
    endtask

    task automatic test_window_length_clamp();
        logic [15:0] lengths[7] = '{16'd0, MIN_WINDOW_LEN - 16'd1, MIN_WINDOW_LEN,
                                    MAX_WINDOW_LEN, MAX_WINDOW_LEN + 16'd1, 16'hFFFF,
                                    16'(dwc_pkg::WINDOW_RESET)};
        for (int k = 0; k < 7; k++) begin
            write_window_length(lengths[k]);
            for (int n = 0; n < 13; n++) begin
                send_request(dwc_pkg::FUNC_FRAME, 16'($urandom()), 16'($urandom()));
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [15:0] l;
        logic [15:0] r;
        for (int n = 0; n < 750; n++) begin
            if (n % 50 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if (n == 250 || n == 500) begin
                case ($urandom_range(0, 2))
                    0: write_window_length(16'($urandom()));
                    1: write_window_length(MIN_WINDOW_LEN);
                    default: write_window_length(MAX_WINDOW_LEN);
                endcase
            end
            if (n == 400) begin
                hold_request = 1'b1;
            end
            if (n >= 400 && n < 470) begin
                idle_on = 1'b0;
            end
            l = 16'($urandom());
            r = 16'($urandom());
            if ($urandom_range(0, 7) == 0) begin
                l = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                r = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            end
            if ($urandom_range(0, 9) == 0) begin
                send_request(dwc_pkg::FUNC_RELEASE, l, r);
            end else begin
                send_request(dwc_pkg::FUNC_FRAME, l, r);
            end
        end
        idle_on = 1'b1;
    endtask

    // full windows at the shortest length: handoff, handoff after restart,
    // cooldown skip, discard while held, release, handoff again
    task automatic test_window_cycle();
        int unsigned frames_per_window;
        int unsigned release_at;
        sparse_idle       = 1'b1;
        idle_on           = 1'b1;
        frames_per_window = int'(MIN_WINDOW_LEN) * dwc_pkg::DECIMATION_DEFAULT;
        write_window_length(MIN_WINDOW_LEN);
        for (int w = 0; w < 5; w++) begin
            release_at = (w == 4) ? $urandom_range(100, frames_per_window - 100)
                                  : frames_per_window;
            for (int unsigned n = 0; n < frames_per_window; n++) begin
                if (n == release_at) begin
                    send_request(dwc_pkg::FUNC_RELEASE, 16'($urandom()), 16'($urandom()));
                end
                send_request(dwc_pkg::FUNC_FRAME, 16'($urandom()), 16'($urandom()));
            end
            if (w == 0) begin
                write_window_length(MIN_WINDOW_LEN);
            end
        end
        sparse_idle = 1'b0;
    endtask

    initial begin
        mismatch_count = 0;
        idle_on        = 1'b1;
        sparse_idle    = 1'b0;
        hold_request   = 1'b0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= dwc_pkg::FUNC_FRAME;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        restart_prediction();
        pred_buffer = 1'b0;
        pred_window = clamp_window_length(16'(dwc_pkg::WINDOW_RESET));
        @(posedge aclk);

        test_directed_frames();
        test_window_length_clamp();
        test_random_traffic();
        test_window_cycle();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
